>>> hdl/ohlcv_candle_aggregator_defines.svh
// Assertion macros shared by the candle aggregator RTL
`ifndef OHLCV_CANDLE_AGGREGATOR_DEFINES_SVH
`define OHLCV_CANDLE_AGGREGATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define OHLCV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define OHLCV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/ohlcv_pkg.sv
// Shared widths, register codes and divider interface types
`timescale 1ns / 1ps
`default_nettype none
package ohlcv_pkg;
	localparam int TS_W         = 48;
	localparam int ID_W         = 48;
	localparam int KEY_W        = 48;
	localparam int QTY_W        = 32;
	localparam int VOL_W        = 48;
	localparam int OUT_PRICE_W  = 32;
	localparam int INTERVAL_W   = 27;
	localparam int PRICE_BITS_DFLT = 32;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int DIV_STEP_BITS = 2;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(60000);

	// register index, taken from paddr[2]
	localparam logic REG_TICK_MODE = 1'b0;
	localparam logic REG_INTERVAL  = 1'b1;

	typedef struct packed {
		logic                  start;
		logic [KEY_W-1:0]      dividend;
		logic [INTERVAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [KEY_W-1:0]      quot;
		logic [INTERVAL_W-1:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> hdl/ohlcv_div.sv
// Shared radix-4 restoring divider: 48-bit key by 27-bit interval
`timescale 1ns / 1ps
`default_nettype none
`include "ohlcv_candle_aggregator_defines.svh"
module ohlcv_div (
	input  wire                clk,
	input  wire                arst_n,
	input  wire ohlcv_pkg::div_req_t req,
	output ohlcv_pkg::div_rsp_t rsp
);
	localparam int DW    = ohlcv_pkg::KEY_W;
	localparam int RW    = ohlcv_pkg::INTERVAL_W;
	localparam int SB    = ohlcv_pkg::DIV_STEP_BITS;
	localparam int STEPS = DW / SB;
	localparam int CW    = $clog2(STEPS);
	localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quot_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [DW-1:0] quot_nx;
	logic [RW-1:0] rem_nx;

	always_comb begin
		logic [RW:0]   part;
		logic [RW-1:0] r;
		logic [DW-1:0] q;
		logic          qb;
		r = rem_q;
		q = quot_q;
		for (int i = 0; i < SB; i++) begin
			part = {r, q[DW-1]};
			if (part >= {1'b0, dvs_q}) begin
				r  = RW'(part - {1'b0, dvs_q});
				qb = 1'b1;
			end else begin
				r  = part[RW-1:0];
				qb = 1'b0;
			end
			q = {q[DW-2:0], qb};
		end
		rem_nx  = r;
		quot_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= quot_nx;
			rem_q  <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

	`OHLCV_ASSERT_IMPL(a_done_not_busy, done_q, !busy_q)
	`OHLCV_ASSERT_IMPL(a_start_when_free, req.start, !busy_q)
	`OHLCV_ASSERT_NEXT(a_last_step_done, busy_q && !req.start && cnt_q == LAST, done_q)
endmodule
`default_nettype wire

>>> hdl/ohlcv_candle_aggregator.sv
// OHLCV candle aggregator top level: sequencer, candle state, APB registers
// Usage:
//  Trades enter on s_tvalid/s_tready/s_tdata, one word per trade. Finished
//  candles leave on m_tvalid/m_tready/m_tdata. tick_mode (addr 0) and
//  interval (addr 4) are written over the APB port; the user must do so
//  only while the block is idle, which the block itself does not enforce.
//  Each trade takes one division of its key by the interval on the shared
//  2-bit-per-cycle divider and, once a candle is open, a second one of the
//  candle's start key; then an update step. A finished candle is loaded
//  into the output register on m_tdata when the update step after the
//  second division completes. The next trade is accepted while it waits
//  there, and only a trade that closes another candle holds in its update
//  step until the register is taken.
//  Reset clears the open candle (the first trade emits nothing), sets
//  tick_mode to 0 and interval to 60000. An interval of 0 acts as 1.
`timescale 1ns / 1ps
`default_nettype none
`include "ohlcv_candle_aggregator_defines.svh"
module ohlcv_candle_aggregator #(
	parameter int PRICE_BITS = ohlcv_pkg::PRICE_BITS_DFLT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// APB configuration
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [ohlcv_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire  [ohlcv_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ohlcv_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	// trades: timestamp_ms, trade_number, price, quantity, zero pad
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [((ohlcv_pkg::TS_W + ohlcv_pkg::ID_W + PRICE_BITS
		+ ohlcv_pkg::QTY_W + 7) / 8) * 8 - 1:0]      s_tdata,
	// candles: start_time, start_id, open, high, low, close, total_volume
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [ohlcv_pkg::TS_W + ohlcv_pkg::ID_W + 4 * ohlcv_pkg::OUT_PRICE_W
		+ ohlcv_pkg::VOL_W - 1:0]                    m_tdata
);
	localparam int TS_W = ohlcv_pkg::TS_W;
	localparam int ID_W = ohlcv_pkg::ID_W;
	localparam int KW   = ohlcv_pkg::KEY_W;
	localparam int QW   = ohlcv_pkg::QTY_W;
	localparam int VW   = ohlcv_pkg::VOL_W;
	localparam int OPW  = ohlcv_pkg::OUT_PRICE_W;
	localparam int IW   = ohlcv_pkg::INTERVAL_W;
	localparam int DW   = ohlcv_pkg::APB_DATA_W;
	localparam int CPW  = (PRICE_BITS < OPW) ? PRICE_BITS : OPW;
	localparam int PX_LO  = TS_W + ID_W;
	localparam int QTY_LO = PX_LO + PRICE_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV_A = 2'd1;
	localparam logic [1:0] ST_DIV_B = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	logic [1:0]            state_q;
	logic                  tick_q;
	logic [IW-1:0]         interval_q;
	logic                  mode_q;
	logic [IW-1:0]         len_q;
	logic [TS_W-1:0]       ts_q;
	logic [ID_W-1:0]       id_q;
	logic [PRICE_BITS-1:0] px_q;
	logic [QW-1:0]         qty_q;
	logic [KW-1:0]         qa_q;
	logic [IW-1:0]         ra_q;
	logic                  closed_q;
	logic                  have_q;
	logic [TS_W-1:0]       cur_time_q;
	logic [ID_W-1:0]       cur_id_q;
	logic [PRICE_BITS-1:0] cur_open_q;
	logic [PRICE_BITS-1:0] cur_high_q;
	logic [PRICE_BITS-1:0] cur_low_q;
	logic [PRICE_BITS-1:0] cur_close_q;
	logic [VW-1:0]         cur_vol_q;
	logic                  m_tvalid_q;
	logic [$bits(m_tdata)-1:0] m_tdata_q;

	ohlcv_pkg::div_req_t   dreq;
	ohlcv_pkg::div_rsp_t   drsp;

	logic                  in_acc;
	logic                  out_free;
	logic                  do_open;
	logic                  do_emit;
	logic                  apply_go;
	logic [KW-1:0]         key;
	logic [KW-1:0]         aligned;
	logic [IW-1:0]         eff_len;
	logic [VW:0]           vol_sum;

	// APB
	wire cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			ohlcv_pkg::REG_TICK_MODE: prdata = DW'(tick_q);
			ohlcv_pkg::REG_INTERVAL:  prdata = DW'(interval_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= 1'b0;
			interval_q <= ohlcv_pkg::INTERVAL_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				ohlcv_pkg::REG_TICK_MODE: tick_q     <= pwdata[0];
				ohlcv_pkg::REG_INTERVAL:  interval_q <= pwdata[IW-1:0];
				default: ;
			endcase
		end
	end

	// handshake and sequencing
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign eff_len  = (interval_q == '0) ? IW'(1) : interval_q;
	assign do_open  = !have_q || closed_q;
	assign do_emit  = have_q && closed_q;
	assign apply_go = (state_q == ST_APPLY) && (!do_emit || out_free);

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = mode_q ? cur_id_q : cur_time_q;
		dreq.divisor  = len_q;
		if (state_q == ST_IDLE) begin
			dreq.start    = in_acc;
			dreq.dividend = tick_q ? s_tdata[PX_LO-1:TS_W] : s_tdata[TS_W-1:0];
			dreq.divisor  = eff_len;
		end else if (state_q == ST_DIV_A) begin
			dreq.start = drsp.done && have_q;
		end
	end

	ohlcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_acc) state_q <= ST_DIV_A;
				ST_DIV_A: if (drsp.done) state_q <= have_q ? ST_DIV_B : ST_APPLY;
				ST_DIV_B: if (drsp.done) state_q <= ST_APPLY;
				ST_APPLY: if (apply_go) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= tick_q;
			len_q  <= eff_len;
			ts_q   <= s_tdata[TS_W-1:0];
			id_q   <= s_tdata[PX_LO-1:TS_W];
			px_q   <= s_tdata[QTY_LO-1:PX_LO];
			qty_q  <= s_tdata[QTY_LO+QW-1:QTY_LO];
		end
		if (state_q == ST_DIV_A && drsp.done) begin
			qa_q     <= drsp.quot;
			ra_q     <= drsp.rem;
			closed_q <= 1'b0;
		end
		if (state_q == ST_DIV_B && drsp.done)
			closed_q <= (drsp.quot != qa_q);
	end

	// candle update
	assign key     = mode_q ? id_q : ts_q;
	assign aligned = key - KW'(ra_q);
	assign vol_sum = {1'b0, cur_vol_q} + (VW + 1)'(qty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (apply_go) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			if (do_open) begin
				cur_time_q  <= mode_q ? ts_q : aligned;
				cur_id_q    <= mode_q ? aligned : id_q;
				cur_open_q  <= px_q;
				cur_high_q  <= px_q;
				cur_low_q   <= px_q;
				cur_close_q <= px_q;
				cur_vol_q   <= VW'(qty_q);
			end else begin
				if (px_q > cur_high_q)
					cur_high_q <= px_q;
				if (px_q < cur_low_q)
					cur_low_q <= px_q;
				cur_close_q <= px_q;
				cur_vol_q   <= vol_sum[VW] ? {VW{1'b1}} : vol_sum[VW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= (apply_go && do_emit) || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go && do_emit)
			m_tdata_q <= {cur_vol_q,
				OPW'(cur_close_q[CPW-1:0]), OPW'(cur_low_q[CPW-1:0]),
				OPW'(cur_high_q[CPW-1:0]), OPW'(cur_open_q[CPW-1:0]),
				cur_id_q, cur_time_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`OHLCV_ASSERT_IMPL(a_div_done_in_div, drsp.done, state_q == ST_DIV_A || state_q == ST_DIV_B)
	`OHLCV_ASSERT_NEXT(a_emit_sets_valid, apply_go && do_emit, m_tvalid_q)
	`OHLCV_ASSERT_IMPL(a_have_never_drops, 1'b1, !$fell(have_q))
	`OHLCV_ASSERT_NEXT(a_accept_starts_div, in_acc, state_q == ST_DIV_A)
endmodule
`default_nettype wire
